>>> src/mwd_pkg.sv
`default_nettype none
package mwd_pkg;

   // result status codes
   localparam logic [1:0] ST_BUSY       = 2'd0;
   localparam logic [1:0] ST_READY      = 2'd1;
   localparam logic [1:0] ST_LEN_ERR    = 2'd2;
   localparam logic [1:0] ST_STRUCT_ERR = 2'd3;

   // register indexes on the csr port
   localparam int unsigned CSR_INDEX_BITS = 8;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BIT_PERIOD   = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PARITY_START = 8'd1;

   localparam int unsigned PERIOD_BITS = 15;
   localparam int unsigned THR_BITS    = 17;
   localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 15'd1000;

   typedef struct packed {
      logic [THR_BITS-1:0] q1;
      logic [THR_BITS-1:0] q3;
      logic [THR_BITS-1:0] q5;
      logic [THR_BITS-1:0] q7;
      logic [THR_BITS-1:0] q9;
   } thresh_type;

   typedef struct packed {
      logic       line_level;
      logic [1:0] half_bit_count;
      logic       in_word;
      logic       parity_acc;
      logic       command_flag;
   } ctl_type;

   // floor(k * period / 4), wide enough never to wrap
   function automatic logic [THR_BITS-1:0] quarter(input logic [3:0] k,
                                                   input logic [PERIOD_BITS-1:0] period);
      logic [THR_BITS+1:0] prod;
      prod = (THR_BITS+2)'(k) * (THR_BITS+2)'(period);
      return prod[THR_BITS+1:2];
   endfunction

   function automatic thresh_type make_thresh(input logic [PERIOD_BITS-1:0] period);
      thresh_type t;
      t.q1 = quarter(4'd1, period);
      t.q3 = quarter(4'd3, period);
      t.q5 = quarter(4'd5, period);
      t.q7 = quarter(4'd7, period);
      t.q9 = quarter(4'd9, period);
      return t;
   endfunction

endpackage
`default_nettype wire

>>> src/mwd_step.sv
`default_nettype none
module mwd_step #(
   parameter int unsigned WORD_BITS  = 16,
   parameter int unsigned TIMER_BITS = 16,
   parameter int unsigned BT_W       = $clog2(WORD_BITS + 1)
) (
   input  wire logic [15:0]              pulse_length,
   input  wire mwd_pkg::thresh_type      thr,
   input  wire logic                     parity_start,
   input  wire mwd_pkg::ctl_type         ctl_cur,
   input  wire logic [BT_W-1:0]          bits_cur,
   input  wire logic [WORD_BITS-1:0]     shift_cur,
   input  wire logic [WORD_BITS-1:0]     held_cur,
   output mwd_pkg::ctl_type              ctl_nxt,
   output logic [BT_W-1:0]               bits_nxt,
   output logic [WORD_BITS-1:0]          shift_nxt,
   output logic [WORD_BITS-1:0]          held_nxt,
   output logic [1:0]                    status
);

   localparam logic [15:0] LEN_MASK =
      (TIMER_BITS >= 16) ? 16'hFFFF : 16'((64'd1 << TIMER_BITS) - 64'd1);

   logic [mwd_pkg::THR_BITS-1:0] len;
   logic                         len_err;
   logic                         is_short;
   logic [2:0]                   cnt;

   assign len      = mwd_pkg::THR_BITS'(pulse_length & LEN_MASK);
   assign len_err  = (len < thr.q1) || (len > thr.q9);
   assign is_short = (len <= thr.q5);

   always_comb begin
      ctl_nxt   = ctl_cur;
      bits_nxt  = bits_cur;
      shift_nxt = shift_cur;
      held_nxt  = held_cur;
      status    = mwd_pkg::ST_BUSY;
      cnt       = 3'd0;

      ctl_nxt.line_level = ~ctl_cur.line_level;

      if (len_err) begin
         bits_nxt               = '0;
         ctl_nxt.half_bit_count = 2'd0;
         ctl_nxt.in_word        = 1'b0;
         status                 = mwd_pkg::ST_LEN_ERR;
      end else begin
         if (is_short) begin
            cnt = {1'b0, ctl_cur.half_bit_count} + 3'd1 + {2'b00, (len > thr.q3)};
            if (cnt > 3'd3) begin
               cnt = 3'd3;
            end
         end else begin
            // sync pulse starts a new word
            ctl_nxt.in_word      = 1'b1;
            shift_nxt            = '0;
            ctl_nxt.parity_acc   = parity_start;
            bits_nxt             = '0;
            cnt                  = (len > thr.q7) ? 3'd2 : 3'd1;
            ctl_nxt.command_flag = ~ctl_nxt.line_level;
         end
         ctl_nxt.half_bit_count = cnt[1:0];

         if (ctl_nxt.half_bit_count == 2'd2 && ctl_nxt.in_word) begin
            if (bits_nxt < BT_W'(WORD_BITS)) begin
               shift_nxt              = {shift_nxt[WORD_BITS-2:0], ctl_nxt.line_level};
               ctl_nxt.parity_acc     = ctl_nxt.parity_acc ^ ctl_nxt.line_level;
               bits_nxt               = bits_nxt + BT_W'(1);
               ctl_nxt.half_bit_count = 2'd0;
            end else begin
               // parity bit closes the word
               held_nxt               = shift_nxt;
               shift_nxt              = '0;
               bits_nxt               = '0;
               ctl_nxt.half_bit_count = 2'd0;
               ctl_nxt.in_word        = 1'b0;
               if (ctl_nxt.line_level != ctl_nxt.parity_acc) begin
                  held_nxt             = ~held_nxt;
                  ctl_nxt.line_level   = ~ctl_nxt.line_level;
                  ctl_nxt.command_flag = ~ctl_nxt.command_flag;
               end
               status = mwd_pkg::ST_READY;
            end
         end

         if (status == mwd_pkg::ST_BUSY && ctl_nxt.half_bit_count == 2'd3) begin
            bits_nxt               = '0;
            ctl_nxt.half_bit_count = 2'd0;
            ctl_nxt.in_word        = 1'b0;
            status                 = mwd_pkg::ST_STRUCT_ERR;
         end
      end
   end

endmodule
`default_nettype wire

>>> src/manchester_word_decoder_top.sv
// Manchester II word decoder, 1553 style.
// req channel: one transfer per line edge, carrying the timer ticks measured
// since the previous edge. rsp channel: exactly one transfer per req transfer,
// in order, giving a status (in progress, word ready, length error, structure
// error), the last completed data word and its command/data sync type.
// csr channel: write bit_period (index 0) or parity_start (index 1) while the
// block is idle; csr_ready is always high, other indexes are ignored. Pulse
// thresholds are recomputed from bit_period on the write.
// A req item is captured in the input register, decoded by the state
// update and captured in the result register, which drives rsp_tvalid.
// Throughput: one item per cycle while the rsp side accepts, set by the
// combinational decoder state update between input and result registers.
// When the rsp side stalls, the result is held and the input register still
// takes one more item; req_tready drops only while both registers are full.
// Reset: bit_period 1000, parity_start 1, decoder state and held word zero,
// both pipeline registers empty.
`default_nettype none
module manchester_word_decoder_top #(
   parameter int unsigned WORD_BITS  = 16,
   parameter int unsigned TIMER_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,     // [15:0] pulse_length
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,     // [15:0] word_data
   output logic [2:0]       rsp_tuser,     // [1:0] status, [2] word_is_command
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [mwd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [15:0] csr_data
);

   localparam int unsigned BT_W = $clog2(WORD_BITS + 1);

   mwd_pkg::thresh_type   thr_ff, thr_in;
   logic                  par_start_ff, par_start_in;

   logic                  s1_valid_ff, s1_valid_in;
   logic [15:0]           s1_len_ff, s1_len_in;

   mwd_pkg::ctl_type      ctl_ff, ctl_in;
   logic [BT_W-1:0]       bits_ff, bits_in;
   logic [WORD_BITS-1:0]  shift_ff, shift_in;
   logic [WORD_BITS-1:0]  held_ff, held_in;

   logic                  out_valid_ff, out_valid_in;
   logic [1:0]            out_status_ff, out_status_in;
   logic [15:0]           out_word_ff, out_word_in;
   logic                  out_cmd_ff, out_cmd_in;

   mwd_pkg::ctl_type      ctl_step;
   logic [BT_W-1:0]       bits_step;
   logic [WORD_BITS-1:0]  shift_step;
   logic [WORD_BITS-1:0]  held_step;
   logic [1:0]            status_step;

   logic                  out_free;
   logic                  s1_move;
   logic                  req_fire;
   logic                  csr_fire;

   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid && csr_ready;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_fire   = req_tvalid && req_tready;

   mwd_step #(
      .WORD_BITS  (WORD_BITS),
      .TIMER_BITS (TIMER_BITS),
      .BT_W       (BT_W)
   ) u_step (
      .pulse_length (s1_len_ff),
      .thr          (thr_ff),
      .parity_start (par_start_ff),
      .ctl_cur      (ctl_ff),
      .bits_cur     (bits_ff),
      .shift_cur    (shift_ff),
      .held_cur     (held_ff),
      .ctl_nxt      (ctl_step),
      .bits_nxt     (bits_step),
      .shift_nxt    (shift_step),
      .held_nxt     (held_step),
      .status       (status_step)
   );

   always_comb begin
      thr_in       = thr_ff;
      par_start_in = par_start_ff;
      if (csr_fire) begin
         unique case (csr_index)
            mwd_pkg::REG_BIT_PERIOD:
               thr_in = mwd_pkg::make_thresh(csr_data[mwd_pkg::PERIOD_BITS-1:0]);
            mwd_pkg::REG_PARITY_START:
               par_start_in = csr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_len_in   = s1_len_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
         s1_len_in   = req_tdata;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      ctl_in        = ctl_ff;
      bits_in       = bits_ff;
      shift_in      = shift_ff;
      held_in       = held_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_status_in = out_status_ff;
      out_word_in   = out_word_ff;
      out_cmd_in    = out_cmd_ff;
      if (s1_move) begin
         ctl_in        = ctl_step;
         bits_in       = bits_step;
         shift_in      = shift_step;
         held_in       = held_step;
         out_valid_in  = 1'b1;
         out_status_in = status_step;
         out_word_in   = 16'(held_step);
         out_cmd_in    = ctl_step.command_flag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= mwd_pkg::make_thresh(mwd_pkg::PERIOD_RESET);
         par_start_ff <= 1'b1;
         s1_valid_ff  <= 1'b0;
         ctl_ff       <= '0;
         bits_ff      <= '0;
         shift_ff     <= '0;
         held_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         thr_ff       <= thr_in;
         par_start_ff <= par_start_in;
         s1_valid_ff  <= s1_valid_in;
         ctl_ff       <= ctl_in;
         bits_ff      <= bits_in;
         shift_ff     <= shift_in;
         held_ff      <= held_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_len_ff     <= s1_len_in;
      out_status_ff <= out_status_in;
      out_word_ff   <= out_word_in;
      out_cmd_ff    <= out_cmd_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_word_ff;
   assign rsp_tuser  = {out_cmd_ff, out_status_ff};

   // a count of three always ends in a structure error, so it is never kept
   a_no_stored_triple: assert property (@(posedge clock) disable iff (reset)
      ctl_ff.half_bit_count != 2'd3)
      else $error("half-bit count of three kept in state");

   a_bits_bound: assert property (@(posedge clock) disable iff (reset)
      bits_ff <= BT_W'(WORD_BITS))
      else $error("bit counter past word length");

   a_ready_closes_word: assert property (@(posedge clock) disable iff (reset)
      (s1_move && status_step == mwd_pkg::ST_READY)
         |=> (!ctl_ff.in_word && bits_ff == '0 && ctl_ff.half_bit_count == 2'd0))
      else $error("word still open after word ready");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> (s1_valid_ff && $stable(s1_len_ff)))
      else $error("input register lost an item while output stalled");

endmodule
`default_nettype wire

>>> dv/manchester_word_decoder_checker.sv
module manchester_word_decoder_checker (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   input  wire logic                               req_tready,
   input  wire logic [15:0]                        req_tdata,  // [15:0] pulse_length
   input  wire logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   input  wire logic [15:0]                        rsp_tdata,  // [15:0] word_data
   input  wire logic [2:0]                         rsp_tuser,  // [1:0] status,
                                                               // [2] word_is_command
   input  wire logic                               csr_valid,
   input  wire logic                               csr_ready,
   input  wire logic [mwd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [15:0]                        csr_data,
   output int                                      mismatch_count,
   output int                                      results_owed,
   output int                                      words_ready,
   output int                                      length_errors,
   output int                                      structure_errors
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned WORD_LEN = 16;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] word;
      logic        is_cmd;
   } decode_type;

   decode_type pending_decodes[$];

   // register copies
   logic [14:0] period_reg;
   logic        parity_init;

   // decoder state
   logic        level;
   logic [1:0]  halves;
   logic        in_word;
   logic [4:0]  bits_in;
   logic [15:0] shift_reg;
   logic        par;
   logic [15:0] last_word;
   logic        cmd;

   initial begin
      mismatch_count   = 0;
      results_owed     = 0;
      words_ready      = 0;
      length_errors    = 0;
      structure_errors = 0;
   end

   function automatic void drop_word();
      bits_in = '0;
      halves  = '0;
      in_word = 1'b0;
   endfunction

   function automatic decode_type decode_pulse(input logic [15:0] ticks);
      int unsigned p, q1, q3, q5, q7, q9, cnt;
      decode_type res;
      p  = period_reg;
      q1 = p / 4;
      q3 = 3 * p / 4;
      q5 = 5 * p / 4;
      q7 = 7 * p / 4;
      q9 = 9 * p / 4;
      res.status = mwd_pkg::ST_BUSY;
      cnt = halves;
      level = ~level;
      if (ticks < q1 || ticks > q9) begin
         drop_word();
         res.status = mwd_pkg::ST_LEN_ERR;
      end else begin
         if (ticks <= q5) begin
            cnt = cnt + 1;
            if (ticks > q3) cnt = cnt + 1;
            if (cnt > 3) cnt = 3;
         end else begin
            // sync pulse opens a new word
            in_word   = 1'b1;
            shift_reg = '0;
            par       = parity_init;
            bits_in   = '0;
            cnt       = (ticks > q7) ? 2 : 1;
            cmd       = ~level;
         end
         halves = cnt[1:0];
         if (halves == 2'd2 && in_word) begin
            if (bits_in < WORD_LEN) begin
               shift_reg = {shift_reg[14:0], level};
               par       = par ^ level;
               bits_in   = bits_in + 1'b1;
               halves    = '0;
            end else begin
               // parity bit closes the word
               last_word = shift_reg;
               shift_reg = '0;
               drop_word();
               if (level != par) begin
                  last_word = ~last_word;
                  level     = ~level;
                  cmd       = ~cmd;
               end
               res.status = mwd_pkg::ST_READY;
            end
         end
         if (res.status == mwd_pkg::ST_BUSY && halves == 2'd3) begin
            drop_word();
            res.status = mwd_pkg::ST_STRUCT_ERR;
         end
      end
      res.word   = last_word;
      res.is_cmd = cmd;
      return res;
   endfunction

   always @(posedge clock) begin
      decode_type seen, want;
      if (reset) begin
         period_reg  = mwd_pkg::PERIOD_RESET;
         parity_init = 1'b1;
         level       = 1'b0;
         halves      = '0;
         in_word     = 1'b0;
         bits_in     = '0;
         shift_reg   = '0;
         par         = 1'b0;
         last_word   = '0;
         cmd         = 1'b0;
         pending_decodes.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == mwd_pkg::REG_BIT_PERIOD)
               period_reg = csr_data[14:0];
            else if (csr_index == mwd_pkg::REG_PARITY_START)
               parity_init = csr_data[0];
         end
         if (rsp_tvalid && rsp_tready) begin
            seen.status = rsp_tuser[1:0];
            seen.word   = rsp_tdata;
            seen.is_cmd = rsp_tuser[2];
            case (seen.status)
               mwd_pkg::ST_READY:      words_ready++;
               mwd_pkg::ST_LEN_ERR:    length_errors++;
               mwd_pkg::ST_STRUCT_ERR: structure_errors++;
               default: ;
            endcase
            if (pending_decodes.size() == 0) begin
               mismatch_count++;
               $display("%0t: rsp transfer with nothing expected, got status %0d word %h cmd %0d",
                        $time, seen.status, seen.word, seen.is_cmd);
            end else begin
               want = pending_decodes.pop_front();
               if (seen !== want) begin
                  mismatch_count++;
                  $display("%0t: rsp mismatch, expected status %0d word %h cmd %0d,",
                           $time, want.status, want.word, want.is_cmd);
                  $display("%0t:    got status %0d word %h cmd %0d",
                           $time, seen.status, seen.word, seen.is_cmd);
               end
            end
         end
         if (req_tvalid && req_tready)
            pending_decodes.push_back(decode_pulse(req_tdata));
      end
      results_owed = pending_decodes.size();
   end

endmodule

>>> dv/manchester_word_decoder_top_test.sv
module manchester_word_decoder_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASES       = 10;
   localparam int PHASE_PULSES = 175;
   localparam logic [mwd_pkg::CSR_INDEX_BITS-1:0] REG_SPARE = 8'd5;
   // threshold edges at the reset period of 1000
   localparam int unsigned EDGE_PROBES[16] = '{0, 65535, 249, 250, 750, 500, 1250, 1251,
                                              1750, 1751, 2250, 2251, 751, 250, 32768, 1000};

   logic                               clock;
   logic                               reset;
   logic                               req_tvalid;
   logic                               req_tready;
   logic [15:0]                        req_tdata;
   logic                               rsp_tvalid;
   logic                               rsp_tready;
   logic [15:0]                        rsp_tdata;
   logic [2:0]                         rsp_tuser;
   logic                               csr_valid;
   logic                               csr_ready;
   logic [mwd_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [15:0]                        csr_data;

   int mismatch_count, results_owed, words_ready, length_errors, structure_errors;

   int  pulses_sent    = 0;
   int  bit_period_now = 1000;
   int  rx_hold_left   = 0;
   int  burst_left     = 0;
   bit  quiet          = 1'b0;

   manchester_word_decoder_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   manchester_word_decoder_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tuser        (rsp_tuser),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .mismatch_count   (mismatch_count),
      .results_owed     (results_owed),
      .words_ready      (words_ready),
      .length_errors    (length_errors),
      .structure_errors (structure_errors)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("%0t: timeout", $time);
      $display("status: fail");
      $finish;
   end

   // result side back-pressure
   initial begin
      int roll;
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rx_hold_left > 0) begin
            rsp_tready = 1'b0;
            rx_hold_left--;
         end else if (quiet) begin
            rsp_tready = 1'b1;
         end else if (stall_left > 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else begin
            roll = $urandom_range(99);
            if (roll < 70) begin
               rsp_tready = 1'b1;
            end else begin
               rsp_tready = 1'b0;
               stall_left = (roll < 95) ? $urandom_range(2) : $urandom_range(40, 10);
            end
         end
      end
   end

   task automatic push_pulse(input logic [15:0] ticks);
      int gap, roll;
      roll = $urandom_range(99);
      if (quiet || burst_left > 0) gap = 0;
      else if (roll < 60)          gap = 0;
      else if (roll < 90)          gap = $urandom_range(3, 1);
      else                         gap = $urandom_range(40, 8);
      if (burst_left > 0) burst_left--;
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  = ticks;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      pulses_sent++;
   endtask

   task automatic csr_write(input logic [mwd_pkg::CSR_INDEX_BITS-1:0] index,
                            input logic [15:0] value);
      csr_index = index;
      csr_data  = value;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (results_owed != 0) @(negedge clock);
   endtask

   // sync, 16 data bits and parity, sent as edge intervals of one or more half bits
   task automatic send_word();
      bit levels[$];
      int runs[$];
      bit s, b;
      int run, style, roll, cut_at, garbled_at, jitter, ticks, q9;
      s     = 1'($urandom_range(1));
      style = $urandom_range(3);
      repeat (3) levels.push_back(s);
      repeat (3) levels.push_back(!s);
      for (int i = 0; i < 17; i++) begin
         case (style)
            0:       b = 1'($urandom_range(1));
            1:       b = 1'b0;
            2:       b = 1'b1;
            default: b = i[0];
         endcase
         if (i == 16) b = 1'($urandom_range(1));
         levels.push_back(b);
         levels.push_back(!b);
      end
      // the last run blends into the idle line before the next word
      run = 1;
      for (int i = 1; i < levels.size(); i++) begin
         if (levels[i] == levels[i-1]) begin
            run++;
         end else begin
            runs.push_back(run);
            run = 1;
         end
      end
      roll       = $urandom_range(99);
      cut_at     = (roll < 10) ? $urandom_range(runs.size() - 1) : runs.size();
      garbled_at = (roll >= 10 && roll < 18) ? $urandom_range(runs.size() - 1) : -1;
      q9 = 9 * bit_period_now / 4;
      push_pulse((q9 >= 65535) ? 16'hFFFF : 16'($urandom_range(65535, q9 + 1)));
      jitter = bit_period_now / 16;
      for (int i = 0; i < cut_at; i++) begin
         ticks = runs[i] * bit_period_now / 2 - jitter + int'($urandom_range(2 * jitter));
         if (ticks > 65535) ticks = 65535;
         if (i == garbled_at) ticks = $urandom_range(65535);
         push_pulse(16'(ticks));
      end
   endtask

   // free-running values and values right at the quarter-period thresholds
   task automatic send_noise();
      int k, v;
      repeat ($urandom_range(6, 1)) begin
         if ($urandom_range(1)) begin
            v = $urandom_range(65535);
         end else begin
            k = 2 * $urandom_range(4) + 1;
            v = k * bit_period_now / 4 + int'($urandom_range(2)) - 1;
            if (v < 0) v = 0;
            if (v > 65535) v = 65535;
         end
         push_pulse(16'(v));
      end
   endtask

   initial begin
      int unsigned setting;
      logic parity_sel;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = mwd_pkg::REG_BIT_PERIOD;
      csr_data   = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         case (phase)
            0:       begin setting = 1000;                        parity_sel = 1'b1; end
            1:       begin setting = 4;                           parity_sel = 1'b0; end
            2:       begin setting = 29127;                       parity_sel = 1'b1; end
            3:       begin setting = $urandom_range(29127, 4);    parity_sel = 1'($urandom); end
            4:       begin setting = 0;                           parity_sel = 1'b1; end
            5:       begin setting = 16'hFFFF;                    parity_sel = 1'b0; end
            6:       begin setting = 2;                           parity_sel = 1'($urandom); end
            7:       begin setting = $urandom_range(64, 4);       parity_sel = 1'b1; end
            8:       begin setting = $urandom_range(3000, 500);   parity_sel = 1'b0; end
            default: begin setting = 16'h83E8;                    parity_sel = 1'($urandom); end
         endcase
         csr_write(mwd_pkg::REG_BIT_PERIOD, 16'(setting));
         csr_write(mwd_pkg::REG_PARITY_START, 16'(($urandom & 32'hFFFE) | parity_sel));
         bit_period_now = setting & 32'h7FFF;
         if (phase == 0) begin
            // an unknown index must leave the period alone
            csr_write(REG_SPARE, 16'h0004);
            foreach (EDGE_PROBES[i]) push_pulse(16'(EDGE_PROBES[i]));
         end
         quiet = (phase == 5);
         if (phase == 3) begin
            rx_hold_left = 300;
            burst_left   = 40;
         end
         while (pulses_sent < (phase + 1) * PHASE_PULSES) begin
            if ($urandom_range(99) < 70) send_word();
            else                         send_noise();
         end
      end
      wait_drained();
      repeat (4) @(negedge clock);

      $display("sent %0d edge intervals over %0d bit period settings and both parity starts",
               pulses_sent, PHASES);
      $display("decoded %0d words, saw %0d length errors and %0d structure errors",
               words_ready, length_errors, structure_errors);
      if (mismatch_count == 0 && results_owed == 0) begin
         $display("status: pass");
      end else begin
         if (results_owed != 0)
            $display("%0t: %0d expected results never arrived", $time, results_owed);
         $display("status: fail");
      end
      $finish;
   end

endmodule

>>> sim.f
src/mwd_pkg.sv
src/mwd_step.sv
src/manchester_word_decoder_top.sv
dv/manchester_word_decoder_checker.sv
dv/manchester_word_decoder_top_test.sv
